// File: hdl/gf256_pkg.sv
// Shared types, action codes and the GF(2^8) multiply for the arithmetic unit.
package gf256_pkg;

    localparam int unsigned ElemWidth = 8;
    localparam int unsigned NumRounds = 8;

    localparam logic [ElemWidth-1:0] ReduceBits = 8'h1B;
    localparam logic [ElemWidth-1:0] InvExponent = 8'd254;
    localparam logic [ElemWidth-1:0] FieldOne = 8'h01;

    typedef logic [ElemWidth-1:0] elem_t;

    typedef enum logic [1:0] {
        ACT_MUL = 2'd0,
        ACT_INV = 2'd1,
        ACT_DIV = 2'd2,
        ACT_POW = 2'd3
    } action_t;

    // One word in flight: running product, current base power, exponent bits left.
    typedef struct packed {
        elem_t acc;
        elem_t base;
        elem_t expo;
    } stage_t;

    function automatic elem_t gf_mul(input elem_t x_in, input elem_t y_in);
        elem_t acc;
        elem_t x;
        acc = '0;
        x = x_in;
        for (int n = 0; n < ElemWidth; n++)
        begin
            if (y_in[n])
            begin
                acc = acc ^ x;
            end
            if (x[ElemWidth-1])
            begin
                x = {x[ElemWidth-2:0], 1'b0} ^ ReduceBits;
            end
            else
            begin
                x = {x[ElemWidth-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

// File: hdl/gf256_decode.sv
// Front stage: maps every action onto acc * base^expo and registers it.
module gf256_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         action,
    input  logic [7:0]         operand_a,
    input  logic [7:0]         operand_b,
    output logic               out_valid,
    output gf256_pkg::stage_t  out_stage
);

    logic              valid_reg;
    logic              valid_next;
    gf256_pkg::stage_t stage_reg;
    gf256_pkg::stage_t stage_next;

    // multiply: a * b^1, inverse: 1 * a^254, divide: a * b^254, power: 1 * a^b.
    // Zero cases fall out naturally: 0^254 = 0, x^0 = 1.
    always_comb
    begin
        valid_next = in_valid;
        unique case (gf256_pkg::action_t'(action))
            gf256_pkg::ACT_MUL:
            begin
                stage_next.acc  = operand_a;
                stage_next.base = operand_b;
                stage_next.expo = gf256_pkg::FieldOne;
            end
            gf256_pkg::ACT_INV:
            begin
                stage_next.acc  = gf256_pkg::FieldOne;
                stage_next.base = operand_a;
                stage_next.expo = gf256_pkg::InvExponent;
            end
            gf256_pkg::ACT_DIV:
            begin
                stage_next.acc  = operand_a;
                stage_next.base = operand_b;
                stage_next.expo = gf256_pkg::InvExponent;
            end
            default:
            begin
                stage_next.acc  = gf256_pkg::FieldOne;
                stage_next.base = operand_a;
                stage_next.expo = operand_b;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// File: hdl/gf256_round.sv
// One registered square-and-multiply round, consuming the low exponent bit.
module gf256_round (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  gf256_pkg::stage_t  in_stage,
    output logic               out_valid,
    output gf256_pkg::stage_t  out_stage
);

    logic              valid_reg;
    logic              valid_next;
    gf256_pkg::stage_t stage_reg;
    gf256_pkg::stage_t stage_next;
    gf256_pkg::elem_t  prod;
    gf256_pkg::elem_t  square;

    // Both products hang off the stage input, so they run side by side.
    assign prod   = gf256_pkg::gf_mul(in_stage.acc, in_stage.base);
    assign square = gf256_pkg::gf_mul(in_stage.base, in_stage.base);

    always_comb
    begin
        valid_next      = in_valid;
        stage_next.acc  = in_stage.expo[0] ? prod : in_stage.acc;
        stage_next.base = square;
        stage_next.expo = {1'b0, in_stage.expo[gf256_pkg::ElemWidth-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// File: hdl/gf256_arithmetic_unit.sv
// GF(2^8) arithmetic unit (poly 0x11B): multiply, inverse, divide, power.
//
// Usage:
//   Input channel: drive action, operand_a and operand_b and raise start;
//   a word is taken on every rising edge with start high and busy low.
//   busy is held low: the pipeline takes a new word every cycle.
//   Output channel: done is high for exactly one cycle with result valid in
//   that cycle. Results come back in order of acceptance.
//   Pipeline: one decode stage plus eight square-and-multiply rounds (one per
//   exponent bit), each registered. Throughput: one word per cycle.
//   Every action is folded into acc * base^expo at decode, so all words take
//   the same path and the same time.
//   Reset clears all stage valid bits; words in flight are dropped and done
//   stays low until new words reach the end of the pipe.
//   The receiver cannot stall; done and result must be sampled when shown.
module gf256_arithmetic_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    output logic       done,
    output logic [7:0] result
);

    logic              accept;
    logic              stg_valid [gf256_pkg::NumRounds+1];
    gf256_pkg::stage_t stg_data  [gf256_pkg::NumRounds+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    gf256_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .action    (action),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (stg_valid[0]),
        .out_stage (stg_data[0])
    );

    for (genvar i = 0; i < gf256_pkg::NumRounds; i++)
    begin : g_round
        gf256_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_stage  (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_stage (stg_data[i+1])
        );
    end

    assign done   = stg_valid[gf256_pkg::NumRounds];
    assign result = stg_data[gf256_pkg::NumRounds].acc;

    // Every done traces back to an accepted word exactly one pipe length ago.
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 9))
        else $error("done without a matching accepted word");

    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##9 done)
        else $error("accepted word produced no result");

    a_mul_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(action, 9) == gf256_pkg::ACT_MUL) |->
            result == gf256_pkg::gf_mul($past(operand_a, 9), $past(operand_b, 9)))
        else $error("multiply result mismatch");

    a_pow_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(action, 9) == gf256_pkg::ACT_POW && $past(operand_b, 9) == 8'd0)
            |-> result == gf256_pkg::FieldOne)
        else $error("zero exponent must give one");

endmodule

// File: tb/sv/gf256_arithmetic_unit_tb.sv
// Self-checking testbench for the GF(2^8) arithmetic unit: multiply, inverse, divide, power.
module gf256_arithmetic_unit_tb;

    localparam int NumRandom = 1500;
    localparam int QuietTail = 300;
    localparam int StallLimit = 1000;
    localparam int DrainCycles = 12;

    // Keeps the bytes the unit owes us, in order of acceptance.
    class field_result_tracker;
        gf256_pkg::elem_t expected_bytes[$];
        int errors;
        int checked;
        int per_action[4];

        function new();
            errors = 0;
            checked = 0;
            foreach (per_action[i])
            begin
                per_action[i] = 0;
            end
        endfunction

        function gf256_pkg::elem_t field_product(gf256_pkg::elem_t x_in,
                                                 gf256_pkg::elem_t y_in);
            gf256_pkg::elem_t acc;
            gf256_pkg::elem_t x;
            acc = '0;
            x = x_in;
            for (int n = 0; n < 8; n++)
            begin
                if (y_in[n])
                begin
                    acc ^= x;
                end
                // reduce when the top bit falls off
                x = x[7] ? ({x[6:0], 1'b0} ^ gf256_pkg::ReduceBits) : {x[6:0], 1'b0};
            end
            return acc;
        endfunction

        function gf256_pkg::elem_t field_power(gf256_pkg::elem_t x_in,
                                               gf256_pkg::elem_t e_in);
            gf256_pkg::elem_t acc;
            gf256_pkg::elem_t x;
            gf256_pkg::elem_t e;
            acc = gf256_pkg::FieldOne;
            x = x_in;
            e = e_in;
            if (e == 0)
            begin
                return gf256_pkg::FieldOne;
            end
            if (x == 0)
            begin
                return '0;
            end
            while (e != 0)
            begin
                if (e[0])
                begin
                    acc = field_product(acc, x);
                end
                x = field_product(x, x);
                e = e >> 1;
            end
            return acc;
        endfunction

        function gf256_pkg::elem_t field_inverse(gf256_pkg::elem_t x);
            return (x == 0) ? gf256_pkg::elem_t'(0)
                            : field_power(x, gf256_pkg::InvExponent);
        endfunction

        function gf256_pkg::elem_t predict_byte(gf256_pkg::action_t act,
                                                gf256_pkg::elem_t a, gf256_pkg::elem_t b);
            case (act)
                gf256_pkg::ACT_MUL: return field_product(a, b);
                gf256_pkg::ACT_INV: return field_inverse(a);
                gf256_pkg::ACT_DIV: return (b == 0) ? gf256_pkg::elem_t'(0)
                                                    : field_product(a, field_inverse(b));
                default: return field_power(a, b);
            endcase
        endfunction

        function void note_word(gf256_pkg::action_t act, gf256_pkg::elem_t a,
                                gf256_pkg::elem_t b);
            expected_bytes.push_back(predict_byte(act, a, b));
            per_action[act]++;
        endfunction

        function void check_result(gf256_pkg::elem_t got);
            gf256_pkg::elem_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("result: no word pending, expected none, got %02h", got);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("result: expected %02h, got %02h", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    gf256_pkg::action_t action;
    gf256_pkg::elem_t operand_a;
    gf256_pkg::elem_t operand_b;
    logic done;
    gf256_pkg::elem_t result;

    field_result_tracker tracker;
    int quiet_cycles;

    gf256_arithmetic_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        action = gf256_pkg::ACT_MUL;
        operand_a = '0;
        operand_b = '0;
        quiet_cycles = 0;
        tracker = new();
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels on the rising edge; watchdog on lack of progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                tracker.note_word(action, operand_a, operand_b);
            end
            if (done)
            begin
                tracker.check_result(result);
            end
            if ((start && !busy) || done)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= StallLimit)
            begin
                $display("gf256_arithmetic_unit_tb failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(gf256_pkg::action_t act, gf256_pkg::elem_t a,
                             gf256_pkg::elem_t b);
        start <= 1'b1;
        action <= act;
        operand_a <= a;
        operand_b <= b;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        operand_a <= gf256_pkg::elem_t'($urandom);
        operand_b <= gf256_pkg::elem_t'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic gf256_pkg::elem_t pick_operand();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFF;
            default: return gf256_pkg::elem_t'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int idle_odds;
        #1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner words: extremes of each action plus the zero cases
        send_word(gf256_pkg::ACT_MUL, 8'h00, 8'hFF);
        send_word(gf256_pkg::ACT_MUL, 8'hFF, 8'hFF);
        send_word(gf256_pkg::ACT_MUL, 8'h01, 8'hA5);
        send_word(gf256_pkg::ACT_MUL, 8'h80, 8'h02);
        send_word(gf256_pkg::ACT_INV, 8'h00, 8'hFF);
        send_word(gf256_pkg::ACT_INV, 8'h01, 8'h00);
        send_word(gf256_pkg::ACT_INV, 8'hFF, 8'h5A);
        send_word(gf256_pkg::ACT_INV, 8'h53, 8'h00);
        send_word(gf256_pkg::ACT_DIV, 8'hFF, 8'h00);
        send_word(gf256_pkg::ACT_DIV, 8'h00, 8'h00);
        send_word(gf256_pkg::ACT_DIV, 8'h00, 8'hFF);
        send_word(gf256_pkg::ACT_DIV, 8'hFF, 8'hFF);
        send_word(gf256_pkg::ACT_DIV, 8'h57, 8'h83);
        send_word(gf256_pkg::ACT_POW, 8'h00, 8'h00);
        send_word(gf256_pkg::ACT_POW, 8'hFF, 8'h00);
        send_word(gf256_pkg::ACT_POW, 8'h00, 8'h01);
        send_word(gf256_pkg::ACT_POW, 8'h00, 8'hFF);
        send_word(gf256_pkg::ACT_POW, 8'hFF, 8'hFF);
        send_word(gf256_pkg::ACT_POW, 8'h02, 8'hFE);
        send_word(gf256_pkg::ACT_POW, 8'h03, 8'h80);
        hold_off(3);
        send_word(gf256_pkg::ACT_MUL, 8'hAA, 8'h55);
        wait_drained();
        @(negedge clk);

        idle_odds = 0;
        for (int i = 0; i < NumRandom; i++)
        begin
            // idle density changes every 50 words, and is off for the tail
            if (i % 50 == 0)
            begin
                idle_odds = $urandom_range(0, 3);
            end
            if (i < NumRandom - QuietTail && idle_odds != 0
                && $urandom_range(1, 8) <= idle_odds * 2)
            begin
                hold_off($urandom_range(1, 18));
            end
            if (i == NumRandom / 2)
            begin
                wait_drained();
                @(negedge clk);
            end
            send_word(gf256_pkg::action_t'($urandom_range(0, 3)),
                      pick_operand(), pick_operand());
        end
        wait_drained();
        repeat (DrainCycles) @(negedge clk);

        $display("covered %0d results: %0d mul, %0d inv, %0d div, %0d pow",
                 tracker.checked,
                 tracker.per_action[gf256_pkg::ACT_MUL],
                 tracker.per_action[gf256_pkg::ACT_INV],
                 tracker.per_action[gf256_pkg::ACT_DIV],
                 tracker.per_action[gf256_pkg::ACT_POW]);
        $display("including zero operands, zero divisors and zero exponents");
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("gf256_arithmetic_unit_tb passed");
        end
        else
        begin
            $display("gf256_arithmetic_unit_tb failed");
        end
        $finish;
    end

endmodule
